// ===== hw/rtl/estb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// estb_pkg
// Shared constants, types and table function for the tone burst unit.
// ----------------------------------------------------------------------------
package estb_pkg;

    localparam int PHASE_BITS_DEF   = 24;
    localparam int SINE_ENTRIES_DEF = 1024;
    localparam int LENGTH_BITS_DEF  = 16;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int STEP_W      = 24;
    localparam int BLEN_W      = 16;
    localparam int RAMP_W      = 16;
    localparam int AMP_W       = 15;
    localparam int SAMPLE_W    = 16;
    localparam int SINE_W      = 15;

    localparam int Q16_W       = 16;
    localparam int DIV_STEPS   = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_STEP     = 3'd0,
        CFG_BURST_LENGTH   = 3'd1,
        CFG_ATTACK_LENGTH  = 3'd2,
        CFG_RELEASE_LENGTH = 3'd3,
        CFG_AMPLITUDE      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic mul1;
        logic mul2;
        logic mul3;
        logic mul4;
        logic emit;
    } estb_cmd_t;

    typedef struct packed {
        logic active;
    } estb_status_t;

    // Quarter-wave entry from angle x in Q30, Taylor series to order 17.
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] x);
        logic [63:0] term;
        longint      sum;
        longint      v;
        logic        neg;
        term = x;
        sum  = longint'(term);
        neg  = 1'b1;
        for (int n = 3; n <= 17; n += 2)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'(n * (n - 1));
            if (neg)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
            neg = !neg;
        end
        if (sum < 0)
            sum = 0;
        v = longint'((64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30);
        if (v > 32767)
            v = 32767;
        return v[SINE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/estb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// estb_ctrl
// Sequencer: accepts a word, steps the datapath, holds the output word.
// ----------------------------------------------------------------------------
module estb_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire estb_pkg::estb_status_t status,
    output estb_pkg::estb_cmd_t        cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_FIN
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic [estb_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [estb_pkg::DIV_CNT_W-1:0]   cnt_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             emit_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign emit_ok   = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                cnt_next   = '0;
                state_next = status.active ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == estb_pkg::DIV_CNT_W'(estb_pkg::DIV_STEPS - 1))
                    state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = S_MUL4;
            end
            S_MUL4:
            begin
                cmd.mul4   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (emit_ok)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/estb_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// estb_dp
// Datapath: config registers, burst state, sine ROM, envelope divider,
// multiply chain and output word registers.
// ----------------------------------------------------------------------------
module estb_dp #(
    parameter int PHASE_BITS   = estb_pkg::PHASE_BITS_DEF,
    parameter int SINE_ENTRIES = estb_pkg::SINE_ENTRIES_DEF,
    parameter int LENGTH_BITS  = estb_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [estb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [estb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                restart,
    input  wire estb_pkg::estb_cmd_t                 cmd,
    output estb_pkg::estb_status_t                   status,
    output logic signed [estb_pkg::SAMPLE_W-1:0]     sample_out,
    output logic                                     burst_last,
    output logic                                     burst_active
);

    localparam int KW  = $clog2(SINE_ENTRIES + 1);
    localparam int LW  = LENGTH_BITS;
    localparam int CW  = (LW > estb_pkg::RAMP_W) ? LW : estb_pkg::RAMP_W;
    localparam int FW  = PHASE_BITS - 2;
    localparam int QW  = estb_pkg::Q16_W;
    localparam int SW  = estb_pkg::SINE_W;
    localparam int AW  = estb_pkg::AMP_W;
    localparam int EW  = QW + 1;
    localparam int P3W = AW + SW;
    localparam int P4W = P3W + EW;

    // constant quarter-wave table, registered read
    logic [SW-1:0] sine_rom [SINE_ENTRIES+1];
    for (genvar g = 0; g <= SINE_ENTRIES; g++)
    begin : g_rom
        localparam logic [63:0] X =
            (estb_pkg::HALF_PI_Q30 * 64'(g) + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
        assign sine_rom[g] = estb_pkg::quarter_sine(X);
    end

    logic [estb_pkg::STEP_W-1:0] step_cfg_reg;
    logic [estb_pkg::BLEN_W-1:0] blen_cfg_reg;
    logic [estb_pkg::RAMP_W-1:0] att_cfg_reg;
    logic [estb_pkg::RAMP_W-1:0] rel_cfg_reg;
    logic [AW-1:0]               amp_cfg_reg;

    logic [LW-1:0]         idx_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic                  running_reg;

    logic                  restart_reg;
    logic                  zero_reg;
    logic                  last_reg;
    logic                  full_reg;
    logic                  neg_reg;
    logic [SW-1:0]         sine_reg;
    logic [LW:0]           rem_reg;
    logic [LW-1:0]         den_reg;
    logic [QW-1:0]         quo_reg;
    logic [EW-1:0]         e_reg;
    logic [EW-1:0]         e2_reg;
    logic [EW-1:0]         env_reg;
    logic [P3W-1:0]        p3_reg;
    logic [P4W-1:0]        p4_reg;
    logic signed [estb_pkg::SAMPLE_W-1:0] sample_reg;
    logic                  blast_reg;
    logic                  bactive_reg;

    logic [LW-1:0]         len;
    logic [LW-1:0]         att;
    logic [LW-1:0]         rel;
    logic [estb_pkg::RAMP_W-1:0] att_m;
    logic [estb_pkg::RAMP_W-1:0] rel_m;
    logic                  active;
    logic                  is_last;
    logic                  rel_cond;
    logic                  att_cond;
    logic [FW-1:0]         frac;
    logic [FW+KW-1:0]      kprod;
    logic [KW-1:0]         k;
    logic [KW-1:0]         rom_addr;
    logic [LW:0]           rem2;
    logic [EW-1:0]         e_val;
    logic [2*EW-1:0]       m1;
    logic [EW:0]           factor;
    logic [2*EW:0]         m2;
    logic [P4W-1:0]        m4;
    logic [estb_pkg::SAMPLE_W-1:0] mag;
    logic [estb_pkg::SAMPLE_W-1:0] sat;

    assign len   = LW'(blen_cfg_reg);
    assign att_m = (att_cfg_reg == '0) ? estb_pkg::RAMP_W'(1) : att_cfg_reg;
    assign rel_m = (rel_cfg_reg == '0) ? estb_pkg::RAMP_W'(1) : rel_cfg_reg;
    assign att   = (CW'(att_m) > CW'(len)) ? len : LW'(att_m);
    assign rel   = (CW'(rel_m) > CW'(len)) ? len : LW'(rel_m);

    assign active        = running_reg && (idx_reg < len);
    assign status.active = active;
    assign is_last       = ((LW + 1)'(idx_reg) + 1'b1) == (LW + 1)'(len);
    assign rel_cond      = idx_reg > (len - rel);
    assign att_cond      = idx_reg < att;

    assign frac     = phase_reg[FW-1:0];
    assign kprod    = (FW + KW)'(frac) * (FW + KW)'(SINE_ENTRIES);
    assign k        = kprod[FW+KW-1:FW];
    assign rom_addr = phase_reg[FW] ? (KW'(SINE_ENTRIES) - k) : k;

    assign rem2   = {rem_reg[LW-1:0], 1'b0};
    assign e_val  = full_reg ? EW'(1 << QW) : EW'(quo_reg);
    assign m1     = e_reg * e_reg;
    assign factor = (EW + 1)'(3 << QW) - {e_reg, 1'b0};
    assign m2     = (2 * EW + 1)'(e2_reg) * (2 * EW + 1)'(factor);
    assign m4     = P4W'(p3_reg) * P4W'(env_reg);
    assign mag    = p4_reg[P4W-1 -: estb_pkg::SAMPLE_W];

    always_comb
    begin
        if (neg_reg)
            sat = (mag > 16'd32768) ? 16'h8000 : (~mag + 1'b1);
        else
            sat = (mag > 16'd32767) ? 16'h7fff : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg <= '0;
            blen_cfg_reg <= '0;
            att_cfg_reg  <= estb_pkg::RAMP_W'(1);
            rel_cfg_reg  <= estb_pkg::RAMP_W'(1);
            amp_cfg_reg  <= '0;
            idx_reg      <= '0;
            phase_reg    <= '0;
            running_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    estb_pkg::CFG_PHASE_STEP:     step_cfg_reg <= cfg_data;
                    estb_pkg::CFG_BURST_LENGTH:   blen_cfg_reg <= cfg_data[estb_pkg::BLEN_W-1:0];
                    estb_pkg::CFG_ATTACK_LENGTH:  att_cfg_reg  <= cfg_data[estb_pkg::RAMP_W-1:0];
                    estb_pkg::CFG_RELEASE_LENGTH: rel_cfg_reg  <= cfg_data[estb_pkg::RAMP_W-1:0];
                    estb_pkg::CFG_AMPLITUDE:      amp_cfg_reg  <= cfg_data[AW-1:0];
                    default:                      ;
                endcase
            end
            if (cmd.load && restart)
            begin
                idx_reg     <= '0;
                phase_reg   <= '0;
                running_reg <= (len != '0);
            end
            if (cmd.eval && !active)
                running_reg <= 1'b0;
            if (cmd.emit && !zero_reg)
            begin
                idx_reg   <= idx_reg + 1'b1;
                phase_reg <= phase_reg + PHASE_BITS'(step_cfg_reg);
                if (last_reg)
                    running_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            restart_reg <= restart;
        if (cmd.eval)
        begin
            zero_reg <= !active;
            last_reg <= is_last;
            sine_reg <= sine_rom[rom_addr];
            neg_reg  <= phase_reg[PHASE_BITS-1];
            quo_reg  <= '0;
            if (rel_cond)
            begin
                full_reg <= 1'b0;
                rem_reg  <= (LW + 1)'(len - idx_reg);
                den_reg  <= rel;
            end
            else if (att_cond)
            begin
                full_reg <= 1'b0;
                rem_reg  <= (LW + 1)'(idx_reg);
                den_reg  <= att;
            end
            else
            begin
                full_reg <= 1'b1;
                rem_reg  <= '0;
                den_reg  <= len;
            end
        end
        if (cmd.div_step)
        begin
            if (rem2 >= (LW + 1)'(den_reg))
            begin
                rem_reg <= rem2 - (LW + 1)'(den_reg);
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2;
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.mul1)
        begin
            e_reg  <= e_val;
            p3_reg <= P3W'(amp_cfg_reg) * P3W'(sine_reg);
        end
        if (cmd.mul2)
            e2_reg <= m1[QW +: EW];
        if (cmd.mul3)
            env_reg <= m2[QW +: EW];
        if (cmd.mul4)
            p4_reg <= m4;
        if (cmd.emit)
        begin
            sample_reg  <= zero_reg ? '0 : signed'(sat);
            blast_reg   <= !zero_reg && last_reg;
            bactive_reg <= !zero_reg && !restart_reg | !zero_reg;
        end
    end

    assign sample_out   = sample_reg;
    assign burst_last   = blast_reg;
    assign burst_active = bactive_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/enveloped_sine_tone_burst_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// enveloped_sine_tone_burst_unit
// Sine tone burst generator with smoothstep attack/release envelope.
// ----------------------------------------------------------------------------
// Each input word (restart flag) yields one output word: a signed 16-bit
// sample, a last flag and an active flag. A word passes through the
// 16-step envelope divider followed by four multiply stages; a word outside
// a burst skips both. The next word is accepted the cycle after the output
// register loads, so a new word is not taken before the last one is done. The
// output register holds the word while the next input word is accepted; a
// word still waiting there holds the sequencer before it loads. The user must
// write configuration through cfg_we/cfg_index/cfg_data only while no word is
// in flight; the block itself does not enforce this.
module enveloped_sine_tone_burst_unit #(
    parameter int PHASE_BITS   = estb_pkg::PHASE_BITS_DEF,
    parameter int SINE_ENTRIES = estb_pkg::SINE_ENTRIES_DEF,
    parameter int LENGTH_BITS  = estb_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [estb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [estb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              restart,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [estb_pkg::SAMPLE_W-1:0]   sample_out,
    output logic                                   burst_last,
    output logic                                   burst_active
);

    estb_pkg::estb_cmd_t    cmd;
    estb_pkg::estb_status_t status;

    estb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    estb_dp #(
        .PHASE_BITS   (PHASE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .restart      (restart),
        .cmd          (cmd),
        .status       (status),
        .sample_out   (sample_out),
        .burst_last   (burst_last),
        .burst_active (burst_active)
    );

endmodule
`default_nettype wire
